// ===== rtl/bpa_pkg.sv =====
// Shared types and constants for the bitmap page allocator.
package bpa_pkg;

    localparam int MAX_PAGES_DEF = 32768;
    localparam int WORD_W        = 32;
    localparam int BIT_W         = 5;

    localparam logic [15:0] PAGE_COUNT_RST = 16'd32768;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_FREE    = 2'd1,
        OP_RESERVE = 2'd2
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [14:0] page;
        logic [15:0] count;
    } t_in_item;

    typedef struct packed {
        logic        ok;
        logic [14:0] first_page;
        logic [15:0] used_count;
    } t_out_item;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SRCH,
        S_MARK,
        S_UPD,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic clr;
        logic load;
        logic srch;
        logic mark;
        logic upd;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic in_alloc;
        logic in_upd;
        logic clr_last;
        logic found;
        logic srch_last;
        logic mark_last;
    } t_dp_st;

endpackage

// ===== rtl/bitmap_page_allocator.sv =====
// Bitmap first-fit page allocator, top level.
// One bit per page is kept in a RAM of 32-bit words; a set bit is a page in use.
// After reset the map is swept to zero, one word a cycle, and no beat is taken
// until that is done; page_count is to be written only while no item is in
// flight. Items are handled one at a time.
// Allocate reads S map words in a first-fit scan (at most ceil(limit/32)) and,
// if a run is found, then marks the M words that the run covers; the scan is
// bounded by the single read port of the map RAM. Free and reserve read and
// update one map word; a zero count, no usable pages or op code 3 go straight
// to the result. A result beat waits in an output register, and the next item
// can be taken meanwhile.
module bitmap_page_allocator
    import bpa_pkg::*;
#(
    parameter int MAX_PAGES = MAX_PAGES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_item
);

    t_dp_cmd cmd;
    t_dp_st  st;

    bpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_st        (st),
        .o_cmd       (cmd)
    );

    bpa_dp #(
        .MAX_PAGES (MAX_PAGES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_st        (st),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== rtl/bpa_ram.sv =====
// Generic simple dual-port RAM with registered read.
module bpa_ram
    import bpa_pkg::*;
#(
    parameter int WIDTH = WORD_W,
    parameter int DEPTH = MAX_PAGES_DEF / WORD_W,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/bpa_ctrl.sv =====
// Sequencing state machine for the bitmap page allocator.
module bpa_ctrl
    import bpa_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    input  t_dp_st  i_st,
    output t_dp_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_st.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_st.in_alloc) begin
                        n_state = S_SRCH;
                    end else if (i_st.in_upd) begin
                        n_state = S_UPD;
                    end else begin
                        n_state = S_RESULT;
                    end
                end
            end
            S_SRCH: begin
                o_cmd.srch = 1'b1;
                if (i_st.found) begin
                    n_state = S_MARK;
                end else if (i_st.srch_last) begin
                    n_state = S_RESULT;
                end
            end
            S_MARK: begin
                o_cmd.mark = 1'b1;
                if (i_st.mark_last) begin
                    n_state = S_RESULT;
                end
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = S_RESULT;
            end
            S_RESULT: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/bpa_dp.sv =====
// Datapath: usage map, word scanner, run marker and counters.
module bpa_dp
    import bpa_pkg::*;
#(
    parameter int MAX_PAGES = MAX_PAGES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  t_in_item    i_in_item,
    input  t_dp_cmd     i_cmd,
    output t_dp_st      o_st,
    output t_out_item   o_out_item
);

    localparam int LIM_W = $clog2(MAX_PAGES + 1);
    localparam int PW    = (LIM_W > 16) ? LIM_W : 16;
    localparam int WORDS = (MAX_PAGES + WORD_W - 1) / WORD_W;
    localparam int WA_W  = (WORDS > 1) ? $clog2(WORDS) : 1;

    localparam logic [WORD_W-1:0] ONES = '1;

    logic [15:0]       r_pc;
    logic [PW-1:0]     r_used, n_used;
    logic [WA_W-1:0]   r_word, n_word;
    t_op               r_op, n_op;
    logic [PW-1:0]     r_page, n_page;
    logic [PW-1:0]     r_n, n_n;
    logic [PW-1:0]     r_run, n_run;
    logic [PW-1:0]     r_start, n_start;
    logic [PW-1:0]     r_end, n_end;
    logic              r_ok, n_ok;
    logic [PW-1:0]     r_first, n_first;
    t_out_item         r_out, n_out;

    logic [WORD_W-1:0] rd;
    logic              ram_we;
    logic [WORD_W-1:0] ram_wdata;

    logic [PW-1:0]     lim;
    logic [PW:0]       lim_words;
    logic [PW-1:0]     base;
    logic [PW-1:0]     word_ext;
    logic [PW-1:0]     lim_hi;
    logic [WORD_W-1:0] vmask;
    logic [WORD_W-1:0] m;
    logic [5:0]        tz;
    logic [5:0]        lz;
    logic [63:0]       h [6];
    logic [63:0]       acc;
    logic              acc_any;
    logic [BIT_W-1:0]  p_int;
    logic              small_n;
    logic              carry_done;
    logic [PW-1:0]     carry_start;
    logic              found;
    logic [PW-1:0]     f_start;
    logic [PW-1:0]     f_end;

    logic [WA_W-1:0]   sw, ew;
    logic [BIT_W-1:0]  lo, hi;
    logic [WORD_W-1:0] mmask;

    logic [BIT_W-1:0]  ubit;
    logic [WORD_W-1:0] umask;
    logic              ucur;
    logic              upd_ok;
    logic [WORD_W-1:0] upd_data;

    // limit and usable-page mask for the word under scan
    always_comb begin
        lim       = (PW'(r_pc) < PW'(MAX_PAGES)) ? PW'(r_pc) : PW'(MAX_PAGES);
        lim_words = ((PW + 1)'(lim) + (PW + 1)'(WORD_W - 1)) >> BIT_W;
        word_ext  = PW'(r_word);
        base      = word_ext << BIT_W;
        lim_hi    = lim >> BIT_W;
        if (word_ext < lim_hi) begin
            vmask = ONES;
        end else if (word_ext == lim_hi) begin
            vmask = ~(ONES << lim[BIT_W-1:0]);
        end else begin
            vmask = '0;
        end
        if (r_word == '0) begin
            vmask[0] = 1'b0;
        end
        m = ~rd & vmask;
    end

    // free-run analysis of one word
    always_comb begin
        tz = 6'd32;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (!m[i]) tz = 6'(i);
        end
        lz = 6'd32;
        for (int i = 0; i < WORD_W; i++) begin
            if (!m[i]) lz = 6'(WORD_W - 1 - i);
        end

        h[0] = {32'b0, m};
        for (int j = 1; j < 6; j++) begin
            h[j] = h[j-1] & (h[j-1] >> (1 << (j - 1)));
        end
        acc = '1;
        for (int j = 0; j < 6; j++) begin
            if (r_n[j]) acc = h[j] & (acc >> (1 << j));
        end
        acc_any = |acc[WORD_W-1:0];
        p_int   = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (acc[i]) p_int = BIT_W'(i);
        end

        small_n     = (r_n <= PW'(WORD_W));
        carry_done  = ((PW + 1)'(r_run) + (PW + 1)'(tz)) >= (PW + 1)'(r_n);
        carry_start = (r_run == '0) ? base : r_start;
        found       = carry_done || (small_n && acc_any);
        f_start     = carry_done ? carry_start : base + PW'(p_int);
        f_end       = f_start + r_n - PW'(1);
    end

    // run marking
    always_comb begin
        sw    = WA_W'(r_start >> BIT_W);
        ew    = WA_W'(r_end >> BIT_W);
        lo    = (r_word == sw) ? r_start[BIT_W-1:0] : '0;
        hi    = (r_word == ew) ? r_end[BIT_W-1:0] : BIT_W'(WORD_W - 1);
        mmask = (ONES << lo) & (ONES >> (BIT_W'(WORD_W - 1) - hi));
    end

    // single-page free and reserve
    always_comb begin
        ubit   = r_page[BIT_W-1:0];
        umask  = WORD_W'(1) << ubit;
        ucur   = rd[ubit];
        upd_ok = (r_page < lim) &&
                 (((r_op == OP_FREE) && ucur) || ((r_op == OP_RESERVE) && !ucur));
        upd_data = (r_op == OP_FREE) ? (rd & ~umask) : (rd | umask);
    end

    always_comb begin
        o_st.in_alloc  = (i_in_item.op == OP_ALLOC) && (i_in_item.count != '0) &&
                         (lim > PW'(1));
        o_st.in_upd    = (i_in_item.op == OP_FREE) || (i_in_item.op == OP_RESERVE);
        o_st.clr_last  = (r_word == WA_W'(WORDS - 1));
        o_st.found     = found;
        o_st.srch_last = ((PW + 1)'(r_word) == (lim_words - (PW + 1)'(1)));
        o_st.mark_last = (r_word == ew);
    end

    always_comb begin
        n_used  = r_used;
        n_word  = r_word;
        n_op    = r_op;
        n_page  = r_page;
        n_n     = r_n;
        n_run   = r_run;
        n_start = r_start;
        n_end   = r_end;
        n_ok    = r_ok;
        n_first = r_first;
        n_out   = r_out;

        if (i_cmd.clr) begin
            n_word = r_word + WA_W'(1);
        end
        if (i_cmd.load) begin
            n_op    = i_in_item.op;
            n_page  = PW'(i_in_item.page);
            n_n     = PW'(i_in_item.count);
            n_run   = '0;
            n_start = '0;
            n_ok    = 1'b0;
            n_first = '0;
            n_word  = o_st.in_upd ? WA_W'(PW'(i_in_item.page) >> BIT_W) : '0;
        end
        if (i_cmd.srch) begin
            if (found) begin
                n_start = f_start;
                n_end   = f_end;
                n_ok    = 1'b1;
                n_first = f_start;
                n_used  = r_used + r_n;
                n_word  = WA_W'(f_start >> BIT_W);
            end else begin
                n_word = r_word + WA_W'(1);
                if (tz == 6'd32) begin
                    n_run   = r_run + PW'(WORD_W);
                    n_start = carry_start;
                end else begin
                    n_run   = PW'(lz);
                    n_start = base + PW'(WORD_W) - PW'(lz);
                end
            end
        end
        if (i_cmd.mark) begin
            n_word = r_word + WA_W'(1);
        end
        if (i_cmd.upd && upd_ok) begin
            n_ok   = 1'b1;
            n_used = (r_op == OP_FREE) ? r_used - PW'(1) : r_used + PW'(1);
        end
        if (i_cmd.out_load) begin
            n_out.ok         = r_ok;
            n_out.first_page = 15'(r_first);
            n_out.used_count = (r_used > PW'(16'hFFFF)) ? 16'hFFFF : 16'(r_used);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= PAGE_COUNT_RST;
            r_used <= '0;
            r_word <= '0;
        end else begin
            if (i_cfg_we) begin
                r_pc <= i_cfg_wdata;
            end
            r_used <= n_used;
            r_word <= n_word;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_page  <= n_page;
        r_n     <= n_n;
        r_run   <= n_run;
        r_start <= n_start;
        r_end   <= n_end;
        r_ok    <= n_ok;
        r_first <= n_first;
        r_out   <= n_out;
    end

    assign ram_we    = i_cmd.clr || i_cmd.mark || (i_cmd.upd && upd_ok);
    assign ram_wdata = i_cmd.clr ? '0 : (i_cmd.mark ? (rd | mmask) : upd_data);

    bpa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_word),
        .i_wdata (ram_wdata),
        .i_raddr (n_word),
        .o_rdata (rd)
    );

    assign o_out_item = r_out;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the bitmap page allocator: directed table, then random phases.
module tb;
    import bpa_pkg::*;

    localparam int          PAGES     = MAX_PAGES_DEF;
    localparam logic [1:0]  OP_UNUSED = 2'd3;
    localparam int          HOLD_LEN  = 300;
    localparam int          N_PHASES  = 7;

    typedef struct {
        bit          is_cfg;
        logic [15:0] cfg_val;
        t_in_item    req;
        bit          typed;
        t_out_item   want;
    } t_row;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [15:0] i_cfg_wdata = '0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in_item   = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out_item;

    // allocator state as the bench sees it
    bit          page_taken [PAGES];
    int          pages_taken  = 0;
    logic [15:0] page_count_q = PAGE_COUNT_RST;

    t_out_item   results_due [$];
    t_out_item   head;
    int          mismatches   = 0;
    bit          calm         = 1'b0;
    int          squeeze_asks = 0;

    int phase_lim [N_PHASES] = '{40, 200, 8, 96, 300, 33, 32768};
    int phase_len [N_PHASES] = '{60, 60, 30, 70, 70, 60, 50};

    bitmap_page_allocator uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("bitmap_page_allocator verification failed");
        $finish;
    end

    function automatic int page_limit();
        return (page_count_q < PAGES) ? int'(page_count_q) : PAGES;
    endfunction

    // first-fit allocate, free and reserve on the bench's copy of the map
    function automatic t_out_item run_page_op(input t_in_item req);
        t_out_item res;
        int        lim;
        int        run;
        int        start;
        bit        found;
        res   = '0;
        lim   = page_limit();
        run   = 0;
        start = 0;
        found = 1'b0;
        case (req.op)
            OP_ALLOC: begin
                if (req.count != 0) begin
                    for (int p = 1; p < lim && !found; p++) begin
                        if (!page_taken[p]) begin
                            if (run == 0) start = p;
                            run++;
                            if (run == int'(req.count)) found = 1'b1;
                        end else begin
                            run = 0;
                        end
                    end
                    if (found) begin
                        for (int q = start; q < start + int'(req.count); q++) page_taken[q] = 1'b1;
                        pages_taken += int'(req.count);
                        res.ok         = 1'b1;
                        res.first_page = start[14:0];
                    end
                end
            end
            OP_FREE: begin
                if (int'(req.page) < lim && page_taken[req.page]) begin
                    page_taken[req.page] = 1'b0;
                    pages_taken--;
                    res.ok = 1'b1;
                end
            end
            OP_RESERVE: begin
                if (int'(req.page) < lim && !page_taken[req.page]) begin
                    page_taken[req.page] = 1'b1;
                    pages_taken++;
                    res.ok = 1'b1;
                end
            end
            default: ;
        endcase
        res.used_count = (pages_taken > 65535) ? 16'hffff : pages_taken[15:0];
        return res;
    endfunction

    function automatic t_row cfg_row(input logic [15:0] v);
        t_row r;
        r.is_cfg  = 1'b1;
        r.cfg_val = v;
        r.req     = '0;
        r.typed   = 1'b0;
        r.want    = '0;
        return r;
    endfunction

    function automatic t_row req_row(input t_op op, input logic [14:0] pg,
                                     input logic [15:0] cnt);
        t_row r;
        r.is_cfg    = 1'b0;
        r.cfg_val   = '0;
        r.req.op    = op;
        r.req.page  = pg;
        r.req.count = cnt;
        r.typed     = 1'b0;
        r.want      = '0;
        return r;
    endfunction

    function automatic t_row req_is(input t_op op, input logic [14:0] pg,
                                    input logic [15:0] cnt, input logic ok,
                                    input logic [14:0] fp, input logic [15:0] used);
        t_row r;
        r                 = req_row(op, pg, cnt);
        r.typed           = 1'b1;
        r.want.ok         = ok;
        r.want.first_page = fp;
        r.want.used_count = used;
        return r;
    endfunction

    function automatic t_in_item rand_request(input int lim);
        t_in_item req;
        int       pick;
        int       span;
        span      = (lim > 0) ? lim : 1;
        req.op    = OP_ALLOC;
        req.page  = 15'($urandom);
        req.count = 16'($urandom);
        pick      = $urandom_range(99);
        if (pick < 45) begin
            pick = $urandom_range(99);
            if (pick < 4) begin
                req.count = '0;
            end else if (pick < 70) begin
                req.count = 16'($urandom_range(1, 4));
            end else if (pick < 90) begin
                req.count = 16'($urandom_range(1, 32));
            end else if (pick < 97) begin
                req.count = 16'($urandom_range(1, span));
            end
        end else if (pick < 78) begin
            req.op   = OP_FREE;
            req.page = 15'($urandom_range(0, span + 15));
            // mostly aim at pages in use
            for (int t = 0; t < 6 && !page_taken[req.page]; t++) begin
                req.page = 15'($urandom_range(0, span - 1));
            end
        end else if (pick < 98) begin
            req.op = OP_RESERVE;
            if ($urandom_range(19) != 0) req.page = 15'($urandom_range(0, span + 7));
        end else begin
            req.op = t_op'(OP_UNUSED);
        end
        return req;
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic offer(input t_in_item req, input bit typed, input t_out_item want);
        t_out_item due;
        while (!calm && $urandom_range(99) < 22) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= req;
        do @(posedge i_clk); while (o_in_stall);
        due = run_page_op(req);
        results_due.push_back(typed ? want : due);
        @(negedge i_clk);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (results_due.size() != 0) @(negedge i_clk);
    endtask

    task automatic set_page_count(input logic [15:0] v);
        i_cfg_we     <= 1'b1;
        i_cfg_wdata  <= v;
        page_count_q  = v;
        @(negedge i_clk);
        i_cfg_we     <= 1'b0;
    endtask

    // result side: random stalls plus one long hold-off on request
    initial begin : result_side
        int hold_left;
        int squeeze_done;
        hold_left    = 0;
        squeeze_done = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (squeeze_asks != squeeze_done) begin
                squeeze_done = squeeze_asks;
                hold_left    = HOLD_LEN - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= !calm && ($urandom_range(99) < 22);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (results_due.size() == 0) begin
                $display("%0t: result beat with none due, got %p", $time, o_out_item);
                mismatches++;
            end else begin
                head = results_due.pop_front();
                if (o_out_item.ok !== head.ok) begin
                    $display("%0t: ok expected %b, got %b", $time, head.ok, o_out_item.ok);
                    mismatches++;
                end
                if (o_out_item.first_page !== head.first_page) begin
                    $display("%0t: first_page expected %0d, got %0d",
                             $time, head.first_page, o_out_item.first_page);
                    mismatches++;
                end
                if (o_out_item.used_count !== head.used_count) begin
                    $display("%0t: used_count expected %0d, got %0d",
                             $time, head.used_count, o_out_item.used_count);
                    mismatches++;
                end
            end
        end
    end

    initial begin : stimulus
        t_row plan [$];
        int   lim;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        plan.push_back(req_is(OP_ALLOC,   15'h7fff, 16'd0,     1'b0, 15'd0, 16'd0));
        plan.push_back(req_is(OP_ALLOC,   15'd0,    16'd1,     1'b1, 15'd1, 16'd1));
        plan.push_back(req_is(OP_ALLOC,   15'd0,    16'd3,     1'b1, 15'd2, 16'd4));
        plan.push_back(req_is(OP_RESERVE, 15'd0,    16'd0,     1'b1, 15'd0, 16'd5));
        plan.push_back(req_is(OP_RESERVE, 15'd0,    16'hffff,  1'b0, 15'd0, 16'd5));
        plan.push_back(req_is(OP_FREE,    15'd2,    16'd0,     1'b1, 15'd0, 16'd4));
        plan.push_back(req_is(OP_FREE,    15'd2,    16'd0,     1'b0, 15'd0, 16'd4));
        plan.push_back(req_is(OP_RESERVE, 15'h7fff, 16'd0,     1'b1, 15'd0, 16'd5));
        plan.push_back(req_is(OP_ALLOC,   15'd0,    16'd32768, 1'b0, 15'd0, 16'd5));
        plan.push_back(req_is(OP_ALLOC,   15'h7fff, 16'hffff,  1'b0, 15'd0, 16'd5));
        plan.push_back(req_is(t_op'(OP_UNUSED), 15'h7fff, 16'hffff, 1'b0, 15'd0, 16'd5));
        plan.push_back(req_row(OP_ALLOC,   15'd0,    16'd2));
        plan.push_back(req_row(OP_RESERVE, 15'd100,  16'd0));
        plan.push_back(cfg_row(16'hffff));
        plan.push_back(req_row(OP_FREE,    15'h7fff, 16'd0));
        plan.push_back(cfg_row(16'd16));
        plan.push_back(req_row(OP_RESERVE, 15'd16,   16'd0));
        plan.push_back(req_row(OP_FREE,    15'd100,  16'd0));
        plan.push_back(req_row(OP_ALLOC,   15'd0,    16'd15));
        plan.push_back(req_row(OP_ALLOC,   15'd0,    16'd2));
        plan.push_back(cfg_row(16'd0));
        plan.push_back(req_row(OP_ALLOC,   15'd0,    16'd1));
        plan.push_back(req_row(OP_FREE,    15'd1,    16'd0));
        plan.push_back(cfg_row(16'd1));
        plan.push_back(req_row(OP_ALLOC,   15'd0,    16'd1));
        plan.push_back(req_row(OP_FREE,    15'd0,    16'd0));
        plan.push_back(cfg_row(16'd32768));
        plan.push_back(req_row(OP_FREE,    15'd100,  16'd0));

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                settle();
                set_page_count(plan[i].cfg_val);
            end else begin
                offer(plan[i].req, plan[i].typed, plan[i].want);
            end
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            settle();
            set_page_count(16'(phase_lim[ph]));
            lim  = page_limit();
            calm = (ph == 3);
            if (ph == 1) squeeze_asks++;
            for (int n = 0; n < phase_len[ph]; n++) begin
                offer(rand_request(lim), 1'b0, '0);
            end
        end

        settle();
        calm = 1'b0;
        repeat (200) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("bitmap_page_allocator verification clean");
        end else begin
            $display("bitmap_page_allocator verification failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/bpa_pkg.sv
rtl/bpa_ram.sv
rtl/bpa_ctrl.sv
rtl/bpa_dp.sv
rtl/bitmap_page_allocator.sv
bench/tb.sv
